### src/line_follow_pid_controller_defines.svh
// Assertion macros used by the line follower PID controller checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef LINE_FOLLOW_PID_CONTROLLER_DEFINES_SVH
`define LINE_FOLLOW_PID_CONTROLLER_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define LFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/lfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the line follower PID controller.
// No dependencies; imported by every module of the block.
package lfp_pkg;

  localparam int unsigned NumSensors = 6;
  localparam int unsigned SampleW    = 10;
  localparam int unsigned DutyW      = 8;
  localparam int unsigned ErrW       = 7;   // position error, -50..50
  localparam int unsigned WsumW      = 8;   // weight sum, -90..90
  localparam int unsigned CntW       = 3;   // sensors on the line, 0..6
  localparam int unsigned EsumW      = 10;  // clamped error sum
  localparam int unsigned ProdW      = 16;  // gain times operand magnitude
  localparam int unsigned PidW       = 15;  // sum of the three scaled terms
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InTdataW   = 64;
  localparam int unsigned OutTdataW  = 32;
  localparam int unsigned QueueDepthDef = 2;

  // x / 10 == (x * Div10Recip) >> Div10Shift for every 16 bit x
  localparam logic [ProdW-1:0] Div10Recip = 16'hCCCD;
  localparam int unsigned      Div10Shift = 19;

  localparam logic [7:0]  BaseSpeedRst     = 8'd60;
  localparam logic [9:0]  LineThresholdRst = 10'd512;
  localparam logic [15:0] LostLimitRst     = 16'd600;
  localparam logic [7:0]  DutyCapRst       = 8'd138;
  localparam logic [7:0]  GainPRst         = 8'd30;
  localparam logic [7:0]  GainIRst         = 8'd1;
  localparam logic [7:0]  GainDRst         = 8'd20;
  localparam logic [7:0]  IntegralLimitRst = 8'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBaseSpeed     = 3'd0,
    CfgLineThreshold = 3'd1,
    CfgLostLimit     = 3'd2,
    CfgDutyCap       = 3'd3,
    CfgGainP         = 3'd4,
    CfgGainI         = 3'd5,
    CfgGainD         = 3'd6,
    CfgIntegralLimit = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  base_duty;
    logic [9:0]  sense_thresh;
    logic [15:0] lost_limit;
    logic [7:0]  duty_cap;
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
    logic [7:0]  gain_d;
    logic [7:0]  integral_limit;
  } cfg_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic [NumSensors-1:0]   mask;
    logic signed [WsumW-1:0] wsum;
    logic [CntW-1:0]         cnt;
  } item_t;

  typedef struct packed {
    logic [ErrW-1:0]       perr;
    logic                  lost;
    logic [NumSensors-1:0] mask;
    logic [DutyW-1:0]      right;
    logic [DutyW-1:0]      left;
  } res_t;

  function automatic logic signed [WsumW-1:0] pos_weight(input int unsigned idx);
    logic signed [WsumW-1:0] w;
    case (idx)
      0:       w = -8'sd50;
      1:       w = -8'sd30;
      2:       w = -8'sd10;
      3:       w = 8'sd10;
      4:       w = 8'sd30;
      default: w = 8'sd50;
    endcase
    return w;
  endfunction

endpackage

### src/lfp_front.sv
`timescale 1ns / 1ps
// Front end: accepts sample requests, thresholds them into a line mask and
// forms the weight sum and hit count. Depends on lfp_pkg.
module lfp_front import lfp_pkg::*; (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NumSensors*SampleW-1:0] samples_i,
  input  logic [SampleW-1:0]            sense_thresh_i,
  input  logic                          full_i,
  output logic                          push_o,
  output item_t                         item_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o = '0;
    for (int i = 0; i < NumSensors; i++) begin
      if (samples_i[i*SampleW +: SampleW] < sense_thresh_i) begin
        item_o.mask[i] = 1'b1;
        item_o.wsum    = item_o.wsum + pos_weight(i);
        item_o.cnt     = item_o.cnt + 1'b1;
      end
    end
  end

endmodule

### src/lfp_queue.sv
`timescale 1ns / 1ps
// Short queue of classified requests between front and back end.
// Depends on lfp_pkg for the entry type. Depth must be at least 2.
module lfp_queue import lfp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FillW'(Depth));
  assign valid_o = (fill_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### src/lfp_back.sv
`timescale 1ns / 1ps
// Back end: sequencer that runs the mode logic, the bit serial position
// divide and the three PID terms, and holds the result register. Depends on lfp_pkg.
module lfp_back import lfp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  localparam int unsigned DivSteps = ErrW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned QuotW    = 2 * ProdW - Div10Shift;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] SInteg = 3'd2;
  localparam logic [2:0] SMul   = 3'd3;
  localparam logic [2:0] SRecip = 3'd4;
  localparam logic [2:0] SAcc   = 3'd5;
  localparam logic [2:0] SDuty  = 3'd6;
  localparam logic [2:0] SOut   = 3'd7;

  localparam logic [1:0] TermP = 2'd0;
  localparam logic [1:0] TermI = 2'd1;
  localparam logic [1:0] TermD = 2'd2;

  logic [2:0]              state_q, state_d;
  logic                    lost_q, lost_d;
  logic [15:0]             miss_q, miss_d;
  logic signed [ErrW-1:0]  prev_q, prev_d;
  logic signed [EsumW-1:0] esum_q, esum_d;
  logic [DutyW-1:0]        held_l_q, held_l_d;
  logic [DutyW-1:0]        held_r_q, held_r_d;
  logic                    kick_q, kick_d;
  logic [NumSensors-1:0]   mask_q, mask_d;
  logic                    neg_q, neg_d;
  logic [CntW-1:0]         divisor_q, divisor_d;
  logic [CntW-1:0]         div_rem_q, div_rem_d;
  logic [DivSteps-1:0]     div_quo_q, div_quo_d;
  logic [DivCntW-1:0]      div_cnt_q, div_cnt_d;
  logic signed [ErrW-1:0]  e_q, e_d;
  logic signed [ErrW:0]    d_q, d_d;
  logic [1:0]              term_q, term_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic                    psign_q, psign_d;
  logic [QuotW-1:0]        quot10_q, quot10_d;
  logic signed [PidW-1:0]  pid_q, pid_d;
  logic                    out_valid_q, out_valid_d;
  res_t                    res_q, res_d;

  logic [DutyW-1:0]        start_duty_w, half_duty_w;
  logic [WsumW-1:0]        wsum_abs_w;
  logic [CntW:0]           rem_sh_w;
  logic                    rem_ge_w;
  logic signed [ErrW-1:0]  e_w;
  logic signed [ErrW:0]    d_w;
  logic signed [EsumW:0]   es_sum_w, lim_w;
  logic signed [EsumW-1:0] opnd_w;
  logic [DutyW-1:0]        opnd_mag_w, gain_w;
  logic [2*ProdW-1:0]      recip_w;
  logic signed [PidW:0]    left_w, right_w;
  logic                    out_free_w;

  function automatic logic [DutyW-1:0] clamp_duty(input logic signed [PidW:0] v,
                                                  input logic [DutyW-1:0] cap);
    logic [DutyW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({8'b0, cap})) begin
      r = cap;
    end else begin
      r = v[DutyW-1:0];
    end
    return r;
  endfunction

  assign start_duty_w = (cfg_i.base_duty > cfg_i.duty_cap) ? cfg_i.duty_cap
                                                           : cfg_i.base_duty;
  assign half_duty_w  = ((cfg_i.base_duty >> 1) > cfg_i.duty_cap) ? cfg_i.duty_cap
                                                                  : (cfg_i.base_duty >> 1);
  assign wsum_abs_w = q_item_i.wsum[WsumW-1] ? WsumW'(-q_item_i.wsum) : q_item_i.wsum;

  // one quotient bit per cycle
  assign rem_sh_w = {div_rem_q, div_quo_q[DivSteps-1]};
  assign rem_ge_w = (rem_sh_w >= {1'b0, divisor_q});

  assign e_w      = neg_q ? -$signed(div_quo_q) : $signed(div_quo_q);
  assign d_w      = (ErrW+1)'(e_w) - (ErrW+1)'(prev_q);
  assign es_sum_w = (EsumW+1)'(esum_q) + (EsumW+1)'(e_w);
  assign lim_w    = $signed({3'b000, cfg_i.integral_limit});

  always_comb begin
    unique case (term_q)
      TermP: begin
        opnd_w = EsumW'(e_q);
        gain_w = cfg_i.gain_p;
      end
      TermI: begin
        opnd_w = esum_q;
        gain_w = cfg_i.gain_i;
      end
      TermD: begin
        opnd_w = EsumW'(d_q);
        gain_w = cfg_i.gain_d;
      end
      default: begin
        opnd_w = '0;
        gain_w = '0;
      end
    endcase
  end

  assign opnd_mag_w = opnd_w[EsumW-1] ? DutyW'(-opnd_w) : opnd_w[DutyW-1:0];
  assign recip_w    = prod_q * Div10Recip;
  assign left_w     = $signed({8'b0, cfg_i.base_duty}) - (PidW+1)'(pid_q);
  assign right_w    = $signed({8'b0, cfg_i.base_duty}) + (PidW+1)'(pid_q);
  assign out_free_w = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    lost_d      = lost_q;
    miss_d      = miss_q;
    prev_d      = prev_q;
    esum_d      = esum_q;
    held_l_d    = held_l_q;
    held_r_d    = held_r_q;
    kick_d      = kick_q;
    mask_d      = mask_q;
    neg_d       = neg_q;
    divisor_d   = divisor_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_cnt_d   = div_cnt_q;
    e_d         = e_q;
    d_d         = d_q;
    term_d      = term_q;
    prod_d      = prod_q;
    psign_d     = psign_q;
    quot10_d    = quot10_q;
    pid_d       = pid_q;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          mask_d  = q_item_i.mask;
          state_d = SOut;
          if (kick_q) begin
            held_l_d = start_duty_w;
            held_r_d = start_duty_w;
            kick_d   = 1'b0;
          end
          if (!lost_q) begin
            if (q_item_i.mask == '0) begin
              miss_d = miss_q + 1'b1;
              if (miss_d >= cfg_i.lost_limit) begin
                lost_d = 1'b1;
                miss_d = '0;
              end
            end else begin
              miss_d    = '0;
              neg_d     = q_item_i.wsum[WsumW-1];
              divisor_d = q_item_i.cnt;
              div_rem_d = '0;
              div_quo_d = wsum_abs_w[DivSteps-1:0];
              div_cnt_d = '0;
              state_d   = SDiv;
            end
          end else if (q_item_i.mask != '0) begin
            lost_d = 1'b0;
            esum_d = '0;
          end else if (prev_q < 0) begin
            held_l_d = '0;
            held_r_d = half_duty_w;
          end else begin
            held_l_d = half_duty_w;
            held_r_d = '0;
          end
        end
      end
      SDiv: begin
        div_rem_d = rem_ge_w ? CntW'(rem_sh_w - {1'b0, divisor_q}) : rem_sh_w[CntW-1:0];
        div_quo_d = {div_quo_q[DivSteps-2:0], rem_ge_w};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = SInteg;
        end
      end
      SInteg: begin
        e_d    = e_w;
        d_d    = d_w;
        prev_d = e_w;
        if (es_sum_w > lim_w) begin
          esum_d = lim_w[EsumW-1:0];
        end else if (es_sum_w < -lim_w) begin
          esum_d = EsumW'(-lim_w);
        end else begin
          esum_d = es_sum_w[EsumW-1:0];
        end
        term_d  = TermP;
        pid_d   = '0;
        state_d = SMul;
      end
      SMul: begin
        prod_d  = gain_w * opnd_mag_w;
        psign_d = opnd_w[EsumW-1];
        state_d = SRecip;
      end
      SRecip: begin
        quot10_d = recip_w[2*ProdW-1:Div10Shift];
        state_d  = SAcc;
      end
      SAcc: begin
        pid_d = psign_q ? pid_q - $signed({2'b00, quot10_q})
                        : pid_q + $signed({2'b00, quot10_q});
        if (term_q == TermD) begin
          state_d = SDuty;
        end else begin
          term_d  = term_q + 1'b1;
          state_d = SMul;
        end
      end
      SDuty: begin
        held_l_d = clamp_duty(left_w, cfg_i.duty_cap);
        held_r_d = clamp_duty(right_w, cfg_i.duty_cap);
        state_d  = SOut;
      end
      SOut: begin
        // hold the finished result until the output register frees up
        if (out_free_w) begin
          out_valid_d = 1'b1;
          res_d.left  = held_l_q;
          res_d.right = held_r_q;
          res_d.mask  = mask_q;
          res_d.lost  = lost_q;
          res_d.perr  = prev_q;
          state_d     = SIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      lost_q      <= 1'b0;
      miss_q      <= '0;
      prev_q      <= '0;
      esum_q      <= '0;
      held_l_q    <= '0;
      held_r_q    <= '0;
      kick_q      <= 1'b1;
      div_cnt_q   <= '0;
      term_q      <= TermP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lost_q      <= lost_d;
      miss_q      <= miss_d;
      prev_q      <= prev_d;
      esum_q      <= esum_d;
      held_l_q    <= held_l_d;
      held_r_q    <= held_r_d;
      kick_q      <= kick_d;
      div_cnt_q   <= div_cnt_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q    <= mask_d;
    neg_q     <= neg_d;
    divisor_q <= divisor_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    e_q       <= e_d;
    d_q       <= d_d;
    prod_q    <= prod_d;
    psign_q   <= psign_d;
    quot10_q  <= quot10_d;
    pid_q     <= pid_d;
    res_q     <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

### src/line_follow_pid_controller.sv
`timescale 1ns / 1ps
// Line follower PID controller. Each request carries six 10 bit reflectance
// samples; each result carries the two motor duties, the line mask, the mode
// and the last position error. A request whose samples see the line while
// following runs through the back end in steps: mode update, the bit serial
// position divide, error and integral update, then for each of the three gain
// terms a multiply, a divide by ten and an accumulate, and finally duty clamp
// and output. Every other request goes from mode update to output. The front
// end classifies requests into a QueueDepth entry queue, so up to QueueDepth
// requests are taken while the back end is busy; results wait in an output
// register. Configuration registers are written through the cfg channel, which
// is always ready; write them only while the block is idle. Depends on lfp_pkg.
module line_follow_pid_controller import lfp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [9:0] sample_far_left, [19:10] sample_left_mid, [29:20] sample_left_inner,
  // [39:30] sample_right_inner, [49:40] sample_right_mid,
  // [59:50] sample_far_right, [63:60] zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] left_duty, [15:8] right_duty, [21:16] line_mask, [22] lost_mode,
  // [29:23] position_error, [31:30] zero
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t  cfg_q;
  item_t front_item;
  item_t queue_item;
  logic  push;
  logic  full;
  logic  pop;
  logic  queue_valid;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_duty      <= BaseSpeedRst;
      cfg_q.sense_thresh   <= LineThresholdRst;
      cfg_q.lost_limit     <= LostLimitRst;
      cfg_q.duty_cap       <= DutyCapRst;
      cfg_q.gain_p         <= GainPRst;
      cfg_q.gain_i         <= GainIRst;
      cfg_q.gain_d         <= GainDRst;
      cfg_q.integral_limit <= IntegralLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBaseSpeed:     cfg_q.base_duty      <= cfg_data_i[7:0];
        CfgLineThreshold: cfg_q.sense_thresh   <= cfg_data_i[9:0];
        CfgLostLimit:     cfg_q.lost_limit     <= cfg_data_i;
        CfgDutyCap:       cfg_q.duty_cap       <= cfg_data_i[7:0];
        CfgGainP:         cfg_q.gain_p         <= cfg_data_i[7:0];
        CfgGainI:         cfg_q.gain_i         <= cfg_data_i[7:0];
        CfgGainD:         cfg_q.gain_d         <= cfg_data_i[7:0];
        CfgIntegralLimit: cfg_q.integral_limit <= cfg_data_i[7:0];
      endcase
    end
  end

  lfp_front u_front (
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .samples_i      (s_axis_tdata[NumSensors*SampleW-1:0]),
    .sense_thresh_i (cfg_q.sense_thresh),
    .full_i         (full),
    .push_o         (push),
    .item_o         (front_item)
  );

  lfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  lfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (queue_valid),
    .q_item_i    (queue_item),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.perr, res.lost, res.mask, res.right, res.left};

endmodule

### src/lfp_checker.sv
`timescale 1ns / 1ps
// Port level checks of the line follower PID controller, bound to the top.
// Depends on lfp_pkg and line_follow_pid_controller_defines.svh.
`include "line_follow_pid_controller_defines.svh"

module lfp_checker import lfp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  logic                   stall_w;
  logic [NumSensors-1:0]  mask_w;
  logic                   lost_w;
  logic signed [ErrW-1:0] perr_w;
  logic                   perr_ok_w;

  assign stall_w   = m_axis_tvalid && !m_axis_tready;
  assign mask_w    = m_axis_tdata[21:16];
  assign lost_w    = m_axis_tdata[22];
  assign perr_w    = m_axis_tdata[29:23];
  assign perr_ok_w = (perr_w >= -7'sd50) && (perr_w <= 7'sd50);

  // a stalled result stays put
  `LFP_ASSERT(a_out_hold, stall_w |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result moved")

  // position error never leaves the weight span
  `LFP_ASSERT(a_perr_range, m_axis_tvalid |-> perr_ok_w, "position error out of range")

  // any sensor on the line drops lost mode at once
  `LFP_ASSERT(a_lost_no_line, m_axis_tvalid && lost_w |-> mask_w == '0, "lost mode with line in view")

  `LFP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "result offered during reset")

endmodule

bind line_follow_pid_controller lfp_checker u_lfp_checker (.*);
